@@ rtl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, fixed-point widths and the CORDIC angle table for the
// quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int VW = 36;       // Q.30 sums
    localparam int TW = 32;       // clamped asin argument
    localparam int XW = 37;       // CORDIC vector components
    localparam int ZW = 36;       // CORDIC angle, Q.30
    localparam int NW = 61;       // square root radicand
    localparam int RW = 62;       // square root partial result
    localparam int SQ_STEPS = 31; // one result bit per cell
    localparam int TABLE_LEN = 24;

    localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] PI_Q30  = ZW'(64'sd3373259426);
    localparam logic [NW-1:0]        ONE_SQ  = NW'(1) << 60;

    typedef struct packed {
        logic signed [VW-1:0] roll_n;
        logic signed [VW-1:0] roll_d;
        logic signed [VW-1:0] yaw_n;
        logic signed [VW-1:0] yaw_d;
        logic signed [TW-1:0] t;
        logic                 clamp;
    } t_carry;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [RW-1:0] res;
    } t_root;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] ang;
        logic                 zero;
    } t_vec;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = ZW'(64'sd843314856);
            5'd1:  v = ZW'(64'sd497837829);
            5'd2:  v = ZW'(64'sd263043836);
            5'd3:  v = ZW'(64'sd133525158);
            5'd4:  v = ZW'(64'sd67021686);
            5'd5:  v = ZW'(64'sd33543515);
            5'd6:  v = ZW'(64'sd16775850);
            5'd7:  v = ZW'(64'sd8388437);
            5'd8:  v = ZW'(64'sd4194282);
            5'd9:  v = ZW'(64'sd2097149);
            5'd10: v = ZW'(64'sd1048575);
            5'd11: v = ZW'(64'sd524287);
            5'd12: v = ZW'(64'sd262143);
            5'd13: v = ZW'(64'sd131071);
            5'd14: v = ZW'(64'sd65535);
            5'd15: v = ZW'(64'sd32767);
            5'd16: v = ZW'(64'sd16383);
            5'd17: v = ZW'(64'sd8191);
            5'd18: v = ZW'(64'sd4095);
            5'd19: v = ZW'(64'sd2047);
            5'd20: v = ZW'(64'sd1023);
            5'd21: v = ZW'(64'sd511);
            5'd22: v = ZW'(64'sd255);
            5'd23: v = ZW'(64'sd127);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Turns a vector with negative x by pi so that vectoring converges.
    function automatic t_vec prerotate(input logic signed [XW-1:0] x,
                                       input logic signed [XW-1:0] y);
        t_vec v;
        v.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            v.x   = -x;
            v.y   = -y;
            v.ang = (y >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
            v.x   = x;
            v.y   = y;
            v.ang = '0;
        end
        return v;
    endfunction

endpackage

@@ rtl/q2e_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit of the restoring integer square root, with the angle operands
// riding alongside.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  q2e_pkg::t_root   i_root,
    input  q2e_pkg::t_carry  i_carry,
    output logic             o_valid,
    output q2e_pkg::t_root   o_root,
    output q2e_pkg::t_carry  o_carry
);

    localparam logic [q2e_pkg::RW-1:0] BIT = q2e_pkg::RW'(1) << (60 - 2 * K);

    logic                   r_valid;
    q2e_pkg::t_root         r_root;
    q2e_pkg::t_carry        r_carry;
    q2e_pkg::t_root         n_root;
    logic [q2e_pkg::RW-1:0] w_sum;

    always_comb begin
        w_sum = i_root.res + BIT;
        if (q2e_pkg::RW'(i_root.n) >= w_sum) begin
            n_root.n   = i_root.n - q2e_pkg::NW'(w_sum);
            n_root.res = (i_root.res >> 1) + BIT;
        end else begin
            n_root.n   = i_root.n;
            n_root.res = i_root.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root  <= n_root;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;
    assign o_carry = r_carry;

endmodule

@@ rtl/q2e_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC iteration applied to the roll, pitch and yaw vectors.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic          i_clamp,
    input  q2e_pkg::t_vec i_vec [3],
    output logic          o_valid,
    output logic          o_clamp,
    output q2e_pkg::t_vec o_vec [3]
);

    localparam logic signed [q2e_pkg::ZW-1:0] ATAN = q2e_pkg::atan_q30(5'(STEP));

    logic          r_valid;
    logic          r_clamp;
    q2e_pkg::t_vec r_vec [3];
    q2e_pkg::t_vec n_vec [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_vec[l].zero = i_vec[l].zero;
            if (i_vec[l].y >= 0) begin
                n_vec[l].x   = i_vec[l].x + (i_vec[l].y >>> STEP);
                n_vec[l].y   = i_vec[l].y - (i_vec[l].x >>> STEP);
                n_vec[l].ang = i_vec[l].ang + ATAN;
            end else begin
                n_vec[l].x   = i_vec[l].x - (i_vec[l].y >>> STEP);
                n_vec[l].y   = i_vec[l].y + (i_vec[l].x >>> STEP);
                n_vec[l].ang = i_vec[l].ang - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clamp <= i_clamp;
            r_vec   <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_clamp = r_clamp;
    assign o_vec   = r_vec;

endmodule

@@ rtl/quaternion_to_euler_angles_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Converts a unit quaternion to ZYX roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
// The unit accepts one quaternion every clock cycle unless the pipeline holds
// (see below) and returns one set of angles per transaction, in order. The
// pipeline is one product stage, one sum stage, one squaring stage, a chain of
// 31 square root cells, one pre-rotation stage, one CORDIC cell per step (steps
// are capped at 24) and the output register. The whole pipeline holds while a
// finished result waits and the sink is not ready.
module quaternion_to_euler_angles_unit #(
    parameter int CORDIC_STEPS   = 16,
    parameter int COMPONENT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, pad
    output logic [0:0]  o_m_axis_tuser    // pitch_clamped
);

    localparam int CB   = COMPONENT_BITS;
    localparam int PW   = 2 * CB;
    localparam int FRAC = 2 * (CB - 1);
    localparam int NS   = (CORDIC_STEPS > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN
                                                               : CORDIC_STEPS;
    localparam int VW   = q2e_pkg::VW;
    localparam int XW   = q2e_pkg::XW;
    localparam int ZW   = q2e_pkg::ZW;
    localparam int QW   = ZW - 17;

    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Components: low CB bits of each field (zero-padded above 16 bits), read as signed.
    logic signed [CB-1:0] w_comp [4];
    for (genvar c = 0; c < 4; c++) begin : g_comp
        logic [CB+15:0] w_ext;
        assign w_ext     = {{CB{1'b0}}, i_s_axis_tdata[16*c +: 16]};
        assign w_comp[c] = signed'(w_ext[CB-1:0]);
    end

    // Stage 1: products.
    localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_ZY = 3, P_WX = 4;
    localparam int P_ZW = 5, P_XY = 6, P_YW = 7, P_ZX = 8;
    logic                 r_v1;
    logic signed [PW-1:0] r_prod [9];
    logic signed [PW-1:0] n_prod [9];

    always_comb begin
        n_prod[P_XX] = w_comp[1] * w_comp[1];
        n_prod[P_YY] = w_comp[2] * w_comp[2];
        n_prod[P_ZZ] = w_comp[3] * w_comp[3];
        n_prod[P_ZY] = w_comp[3] * w_comp[2];
        n_prod[P_WX] = w_comp[0] * w_comp[1];
        n_prod[P_ZW] = w_comp[3] * w_comp[0];
        n_prod[P_XY] = w_comp[1] * w_comp[2];
        n_prod[P_YW] = w_comp[2] * w_comp[0];
        n_prod[P_ZX] = w_comp[3] * w_comp[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= n_prod;
        end
    end

    // Stage 2: Q.30 alignment, sums and clamping of the asin argument.
    logic signed [VW-1:0] w_q [9];
    for (genvar p = 0; p < 9; p++) begin : g_align
        if (FRAC >= 30) begin : g_down
            assign w_q[p] = VW'(r_prod[p] >>> (FRAC - 30));
        end else begin : g_up
            assign w_q[p] = VW'(r_prod[p]) <<< (30 - FRAC);
        end
    end

    logic                 r_v2;
    q2e_pkg::t_carry      r_c2;
    q2e_pkg::t_carry      n_c2;
    logic signed [VW-1:0] w_t;

    always_comb begin
        n_c2.roll_n = (w_q[P_ZY] + w_q[P_WX]) <<< 1;
        n_c2.roll_d = q2e_pkg::ONE_Q30 - ((w_q[P_XX] + w_q[P_YY]) <<< 1);
        n_c2.yaw_n  = (w_q[P_ZW] + w_q[P_XY]) <<< 1;
        n_c2.yaw_d  = q2e_pkg::ONE_Q30 - ((w_q[P_YY] + w_q[P_ZZ]) <<< 1);
        w_t         = (w_q[P_YW] - w_q[P_ZX]) <<< 1;
        if (w_t > q2e_pkg::ONE_Q30) begin
            n_c2.t     = q2e_pkg::TW'(q2e_pkg::ONE_Q30);
            n_c2.clamp = 1'b1;
        end else if (w_t < -q2e_pkg::ONE_Q30) begin
            n_c2.t     = q2e_pkg::TW'(-q2e_pkg::ONE_Q30);
            n_c2.clamp = 1'b1;
        end else begin
            n_c2.t     = q2e_pkg::TW'(w_t);
            n_c2.clamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2 <= n_c2;
        end
    end

    // Stage 3: radicand 1 - t^2.
    logic                          r_v3;
    q2e_pkg::t_carry               r_c3;
    logic [q2e_pkg::NW-1:0]        r_rad;
    logic signed [2*q2e_pkg::TW-1:0] w_tsq;

    assign w_tsq = r_c2.t * r_c2.t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3  <= r_c2;
            r_rad <= q2e_pkg::ONE_SQ - q2e_pkg::NW'(w_tsq);
        end
    end

    // Square root chain.
    logic            w_sv [q2e_pkg::SQ_STEPS+1];
    q2e_pkg::t_root  w_sr [q2e_pkg::SQ_STEPS+1];
    q2e_pkg::t_carry w_sc [q2e_pkg::SQ_STEPS+1];

    assign w_sv[0]     = r_v3;
    assign w_sr[0].n   = r_rad;
    assign w_sr[0].res = '0;
    assign w_sc[0]     = r_c3;

    for (genvar k = 0; k < q2e_pkg::SQ_STEPS; k++) begin : g_sqrt
        q2e_sqrt_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[k]),
            .i_root  (w_sr[k]),
            .i_carry (w_sc[k]),
            .o_valid (w_sv[k+1]),
            .o_root  (w_sr[k+1]),
            .o_carry (w_sc[k+1])
        );
    end

    // Pre-rotation stage.
    q2e_pkg::t_carry w_cf;
    logic            r_v4;
    logic            r_clamp4;
    q2e_pkg::t_vec   r_vec4 [3];

    assign w_cf = w_sc[q2e_pkg::SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_sv[q2e_pkg::SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_clamp4  <= w_cf.clamp;
            r_vec4[0] <= q2e_pkg::prerotate(XW'(w_cf.roll_d), XW'(w_cf.roll_n));
            r_vec4[1] <= q2e_pkg::prerotate(XW'(w_sr[q2e_pkg::SQ_STEPS].res),
                                            XW'(w_cf.t));
            r_vec4[2] <= q2e_pkg::prerotate(XW'(w_cf.yaw_d), XW'(w_cf.yaw_n));
        end
    end

    // CORDIC chain.
    logic          w_cv [NS+1];
    logic          w_cc [NS+1];
    q2e_pkg::t_vec w_cl [NS+1][3];

    assign w_cv[0] = r_v4;
    assign w_cc[0] = r_clamp4;
    assign w_cl[0] = r_vec4;

    for (genvar s = 0; s < NS; s++) begin : g_cordic
        q2e_cordic_cell #(.STEP(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[s]),
            .i_clamp (w_cc[s]),
            .i_vec   (w_cl[s]),
            .o_valid (w_cv[s+1]),
            .o_clamp (w_cc[s+1]),
            .o_vec   (w_cl[s+1])
        );
    end

    // Output: rounding to 13 fraction bits and saturation.
    function automatic logic signed [15:0] to_q13(input q2e_pkg::t_vec v,
                                                  input logic signed [15:0] lim);
        logic signed [ZW-1:0] sum;
        logic signed [QW-1:0] r;
        sum = v.ang + ZW'(64'sd65536);
        r   = QW'(sum >>> 17);
        if (v.zero) begin
            r = '0;
        end else if (r > QW'(lim)) begin
            r = QW'(lim);
        end else if (r < -QW'(lim)) begin
            r = -QW'(lim);
        end
        return 16'(r);
    endfunction

    logic               r_out_valid;
    logic signed [15:0] r_roll;
    logic signed [14:0] r_pitch;
    logic signed [15:0] r_yaw;
    logic               r_clamp;
    logic signed [15:0] w_pitch;

    assign w_pitch = to_q13(w_cl[NS][1], 16'sd12868);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll  <= to_q13(w_cl[NS][0], 16'sd25736);
            r_pitch <= w_pitch[14:0];
            r_yaw   <= to_q13(w_cl[NS][2], 16'sd25736);
            r_clamp <= w_cc[NS];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_yaw, r_pitch, r_roll};
    assign o_m_axis_tuser  = r_clamp;

    ap_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_roll <= 16'sd25736 && r_roll >= -16'sd25736))
        else $error("roll out of range");

    ap_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pitch <= 15'sd12868 && r_pitch >= -15'sd12868))
        else $error("pitch out of range");

    ap_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while output is stalled");

endmodule

@@ tb/sv/tb_quaternion_to_euler_angles_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_unit
// Self-checking bench for the quaternion to Euler angle converter. Quaternions
// are streamed in, some with random gaps; each one is converted by a bit-exact
// integer model of the CORDIC datapath, and every output transaction is
// compared in order against the predicted roll, pitch, yaw and clamp flag.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_unit;

    localparam int STEPS = 16;
    localparam int CBITS = 16;
    localparam int LATENCY = 36 + STEPS;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_angles;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    t_angles angles_due[$];
    int      errors = 0;
    int      n_sent = 0;
    int      n_clamped = 0;
    int      n_checked = 0;
    bit      sink_hold = 1'b0;
    bit      sink_random = 1'b1;

    quaternion_to_euler_angles_unit #(
        .CORDIC_STEPS(STEPS),
        .COMPONENT_BITS(CBITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint prod_q30(longint a, longint b);
        longint p;
        p = a * b;
        if (2 * (CBITS - 1) >= 30) return floor_shift(p, 2 * (CBITS - 1) - 30);
        return p * (64'sd1 << (30 - 2 * (CBITS - 1)));
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint atan_q30[24] = '{843314856, 497837829, 263043836, 133525158,
            67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
            524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
            1023, 511, 255, 127};
        longint ang;
        longint dx;
        longint dy;
        int     n;
        ang = 0;
        n = (STEPS > 24) ? 24 : STEPS;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            ang = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < n; i++) begin
            dx = floor_shift(x, i);
            dy = floor_shift(y, i);
            if (y >= 0) begin
                x += dy; y -= dx; ang += atan_q30[i];
            end else begin
                x -= dy; y += dx; ang -= atan_q30[i];
            end
        end
        return ang;
    endfunction

    function automatic longint angle_q13(longint a, longint lim);
        longint r;
        r = floor_shift(a + (64'sd1 << 16), 17);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic t_angles euler_from_quat(logic [63:0] q);
        longint  w, x, y, z, xx, yy, zz, rn, rd, yn, yd, t, c;
        longint  one;
        t_angles r;
        one = 64'sd1 << 30;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        xx = prod_q30(x, x);
        yy = prod_q30(y, y);
        zz = prod_q30(z, z);
        rn = 2 * (prod_q30(z, y) + prod_q30(w, x));
        rd = one - 2 * (xx + yy);
        yn = 2 * (prod_q30(z, w) + prod_q30(x, y));
        yd = one - 2 * (yy + zz);
        t = 2 * (prod_q30(y, w) - prod_q30(z, x));
        r.clamped = 1'b0;
        if (t > one) begin t = one; r.clamped = 1'b1; end
        if (t < -one) begin t = -one; r.clamped = 1'b1; end
        c = floor_sqrt(longint'(one * one - t * t));
        r.roll = 16'(angle_q13(vector_angle(rn, rd), 25736));
        r.pitch = 15'(angle_q13(vector_angle(t, c), 12868));
        r.yaw = 16'(angle_q13(vector_angle(yn, yd), 25736));
        return r;
    endfunction

    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, bit gaps);
        int gap;
        gap = 0;
        if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                     : $urandom_range(0, 2);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {z, y, x, w};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        angles_due.push_back(euler_from_quat({z, y, x, w}));
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        if (sink_hold) i_m_axis_tready <= 1'b0;
        else if (!sink_random) i_m_axis_tready <= 1'b1;
        else i_m_axis_tready <= ($urandom_range(0, 19) == 0) ? 1'b0
                                : ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[15:0], o_m_axis_tdata[30:16],
                   o_m_axis_tdata[46:31], o_m_axis_tuser[0]};
            if (angles_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = angles_due.pop_front();
                n_checked++;
                if (got.clamped) n_clamped++;
                if (got !== want) begin
                    $display("%0t: mismatch expected r=%0d p=%0d y=%0d c=%0b actual r=%0d p=%0d y=%0d c=%0b",
                             $time, want.roll, want.pitch, want.yaw, want.clamped,
                             got.roll, got.pitch, got.yaw, got.clamped);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (angles_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [15:0] v[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                              16'hFFFF, 16'h5A82};
        send_quat(16'h7FFF, 0, 0, 0, 1'b0);
        send_quat(0, 0, 0, 0, 1'b0);
        send_quat(16'h8000, 0, 0, 0, 1'b0);
        send_quat(16'h5A82, 0, 16'h5A82, 0, 1'b0);
        send_quat(16'h5A82, 0, 16'hA57E, 0, 1'b0);
        send_quat(16'h7FFF, 0, 16'h7FFF, 0, 1'b0);
        send_quat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_quat(0, 16'h7FFF, 0, 0, 1'b0);
        send_quat(0, 0, 0, 16'h7FFF, 1'b0);
        send_quat(0, 0, 0, 16'h8000, 1'b0);
        for (int i = 0; i < 6; i++) send_quat(v[i], v[5 - i], v[i], v[(i + 2) % 6], 1'b1);
        send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        i_s_axis_tvalid <= 1'b0;
        drain();
    endtask

    function automatic logic [15:0] near_unit_comp(real c);
        return 16'($rtoi(c * 32767.0) + $signed($urandom_range(0, 6)) - 3);
    endfunction

    task automatic test_random(int count);
        real a, b, c, d, n;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                a = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                b = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                c = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                d = $itor($signed($urandom_range(0, 2000))) - 1000.0;
                n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
                send_quat(near_unit_comp(a / n), near_unit_comp(b / n),
                          near_unit_comp(c / n), near_unit_comp(d / n), 1'b1);
            end else begin
                send_quat(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), $urandom_range(0, 1));
            end
        end
    endtask

    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 120; i++)
                send_quat(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 1'b0);
        join
        i_s_axis_tvalid <= 1'b0;
        drain();
    endtask

    task automatic test_full_rate();
        sink_random = 1'b0;
        for (int i = 0; i < 200; i++)
            send_quat(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'b0);
        i_s_axis_tvalid <= 1'b0;
        drain();
        sink_random = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        i_s_axis_tvalid <= 1'b0;
        drain();
        test_backpressure();
        test_full_rate();
        test_random(500);
        i_s_axis_tvalid <= 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d quaternions, checked %0d angle sets, %0d with clamped pitch.",
                 n_sent, n_checked, n_clamped);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
